@@ rtl/core/stok_pkg.sv @@
package stok_pkg;

  localparam int unsigned MAX_TEXT = 255;
  localparam int unsigned TLEN_W = 9;

  localparam logic [62:0] NUM_MAX = {63{1'b1}};
  localparam logic [23:0] LINE_MAX = {24{1'b1}};
  localparam logic [15:0] COL_MAX = {16{1'b1}};

  localparam logic [5:0] K_END    = 6'd0;
  localparam logic [5:0] K_LPAR   = 6'd1;
  localparam logic [5:0] K_RPAR   = 6'd2;
  localparam logic [5:0] K_LBRK   = 6'd3;
  localparam logic [5:0] K_RBRK   = 6'd4;
  localparam logic [5:0] K_SEMI   = 6'd5;
  localparam logic [5:0] K_COMMA  = 6'd6;
  localparam logic [5:0] K_EQ     = 6'd7;
  localparam logic [5:0] K_EQEQ   = 6'd8;
  localparam logic [5:0] K_GT     = 6'd9;
  localparam logic [5:0] K_GE     = 6'd10;
  localparam logic [5:0] K_LT     = 6'd11;
  localparam logic [5:0] K_LE     = 6'd12;
  localparam logic [5:0] K_PLUS   = 6'd13;
  localparam logic [5:0] K_MINUS  = 6'd14;
  localparam logic [5:0] K_STAR   = 6'd15;
  localparam logic [5:0] K_SLASH  = 6'd16;
  localparam logic [5:0] K_PCT    = 6'd17;
  localparam logic [5:0] K_NUMBER = 6'd18;
  localparam logic [5:0] K_STRING = 6'd19;
  localparam logic [5:0] K_IDENT  = 6'd20;
  localparam logic [5:0] K_KW0    = 6'd21;
  localparam logic [5:0] K_ERROR  = 6'd41;
  localparam logic [5:0] K_TEXT   = 6'd42;

  localparam int unsigned NUM_KW = 20;

  // first character in the low byte, unused bytes zero
  localparam logic [39:0] KW_TABLE [NUM_KW] = '{
    40'h0000006f64, 40'h0000646e65, 40'h0000006669, 40'h006e656874,
    40'h0065736c65, 40'h006e656877, 40'h0000726f66, 40'h006d6f7266,
    40'h0000006f74, 40'h0070657473, 40'h656c696877, 40'h0000726176,
    40'h000074656c, 40'h0000006e69, 40'h00006e7566, 40'h000000726f,
    40'h0000646e61, 40'h0000746f6e, 40'h00006c696e, 40'h0065757274
  };

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } source_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [62:0] number_value;
    logic [7:0]  text_char;
    logic [23:0] start_line;
    logic [15:0] start_column;
    logic        overflow;
    logic        last;
  } result_t;

  // classified input item
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       digit;
    logic       id_start;
    logic       id_char;
    logic [5:0] punct;
  } cls_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } rpush_t;

  function automatic cls_t classify(source_t s);
    cls_t c;
    c.ch       = s.source_byte;
    c.eoi      = s.end_of_input;
    c.digit    = (s.source_byte >= "0") && (s.source_byte <= "9");
    c.id_start = ((s.source_byte >= "a") && (s.source_byte <= "z")) ||
                 ((s.source_byte >= "A") && (s.source_byte <= "Z")) ||
                 (s.source_byte == "_");
    c.id_char  = c.id_start || c.digit;
    case (s.source_byte)
      "(": c.punct = K_LPAR;
      ")": c.punct = K_RPAR;
      "[": c.punct = K_LBRK;
      "]": c.punct = K_RBRK;
      ";": c.punct = K_SEMI;
      ",": c.punct = K_COMMA;
      "+": c.punct = K_PLUS;
      "-": c.punct = K_MINUS;
      "*": c.punct = K_STAR;
      "/": c.punct = K_SLASH;
      "%": c.punct = K_PCT;
      default: c.punct = K_END;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] ident_kind(logic [39:0] win, logic [TLEN_W-1:0] len,
                                            logic ovf);
    logic [5:0] k;
    k = K_IDENT;
    if (!ovf && len <= TLEN_W'(5)) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if (win == KW_TABLE[i]) k = K_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic result_t mk_res(logic [5:0] kind, logic [62:0] num, logic [7:0] ch,
                                     logic [23:0] ln, logic [15:0] col, logic ovf);
    result_t r;
    r.token_kind   = kind;
    r.number_value = num;
    r.text_char    = ch;
    r.start_line   = ln;
    r.start_column = col;
    r.overflow     = ovf;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/stok_front.sv @@
module stok_front
  import stok_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  source_t source,
  output logic    full,
  output logic    valid,
  output cls_t    head,
  input  logic    take
);

  cls_t       q [2];
  logic       wptr, rptr;
  logic [1:0] count;

  logic wr, rd;
  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign wr    = push && !full;
  assign rd    = take && valid;
  assign head  = q[rptr];

  always_ff @(posedge clk) begin
    if (wr) q[wptr] <= classify(source);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd) rptr <= !rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ rtl/core/stok_back.sv @@
module stok_back
  import stok_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_valid,
  input  logic   cfg_data,
  input  logic   valid,
  input  cls_t   item,
  input  logic   space_ok,
  output logic   take,
  output rpush_t rpush
);

  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_NUM     = 9'b000000010,
    M_IDENT   = 9'b000000100,
    M_STR     = 9'b000001000,
    M_STR_ESC = 9'b000010000,
    M_COMMENT = 9'b000100000,
    M_EQ      = 9'b001000000,
    M_GT      = 9'b010000000,
    M_LT      = 9'b100000000
  } mode_t;

  mode_t             mode, mode_next;
  logic              nl_end;
  logic [62:0]       acc, acc_next;
  logic [39:0]       win, win_next;
  logic [TLEN_W-1:0] tlen, tlen_next;
  logic [23:0]       line, line_next, tsl, tsl_next;
  logic [15:0]       col, col_next, tsc, tsc_next;
  logic              ovf, ovf_next;

  logic        fire;
  logic        use_fl, sec_v, tx_req, do_fresh;
  logic [7:0]  tx_ch;
  result_t     fl, sec, fr;
  logic        fr_v;
  mode_t       fr_mode;
  logic [66:0] acc_x10;
  logic [3:0]  dig;

  assign fire = valid && space_ok;
  assign take = fire;
  assign dig  = item.ch[3:0] - 4'd0;
  assign acc_x10 = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {63'd0, dig};

  // flush of the pending token
  always_comb begin
    fl = mk_res(K_END, '0, '0, tsl, tsc, 1'b0);
    case (mode)
      M_NUM:             fl = mk_res(K_NUMBER, acc, '0, tsl, tsc, ovf);
      M_IDENT:           fl = mk_res(ident_kind(win, tlen, ovf), '0, '0, tsl, tsc, ovf);
      M_STR, M_STR_ESC:  fl = mk_res(K_STRING, '0, '0, tsl, tsc, ovf);
      M_EQ:              fl = mk_res(K_EQ, '0, '0, tsl, tsc, 1'b0);
      M_GT:              fl = mk_res(K_GT, '0, '0, tsl, tsc, 1'b0);
      M_LT:              fl = mk_res(K_LT, '0, '0, tsl, tsc, 1'b0);
      default:           fl = mk_res(K_END, '0, '0, tsl, tsc, 1'b0);
    endcase
  end

  // a byte met between tokens; position is that before this byte
  always_comb begin
    fr_v    = 1'b0;
    fr_mode = M_IDLE;
    fr      = mk_res(K_END, '0, '0, line, col, 1'b0);
    if (item.ch[7]) begin
      fr_v = 1'b1;
    end else if (item.punct != K_END) begin
      fr_v = 1'b1;
      fr   = mk_res(item.punct, '0, '0, line, col, 1'b0);
    end else begin
      case (item.ch)
        "=":       fr_mode = M_EQ;
        ">":       fr_mode = M_GT;
        "<":       fr_mode = M_LT;
        " ", 8'h09: fr_mode = M_IDLE;
        8'h0a:     fr_v = nl_end;
        "#":       fr_mode = M_COMMENT;
        8'h22:     fr_mode = M_STR;
        default: begin
          if (item.digit) begin
            fr_mode = M_NUM;
          end else if (item.id_start) begin
            fr_mode = M_IDENT;
            fr_v    = 1'b1;
            fr      = mk_res(K_TEXT, '0, item.ch, line, col, 1'b0);
          end else begin
            fr_v = 1'b1;
            fr   = mk_res(K_ERROR, '0, '0, line, col, 1'b0);
          end
        end
      endcase
    end
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    win_next  = win;
    tlen_next = tlen;
    ovf_next  = ovf;
    tsl_next  = tsl;
    tsc_next  = tsc;
    line_next = line;
    col_next  = col;
    use_fl    = 1'b0;
    sec_v     = 1'b0;
    sec       = fr;
    tx_req    = 1'b0;
    tx_ch     = item.ch;
    do_fresh  = 1'b0;

    if (item.eoi) begin
      use_fl    = (mode == M_NUM) || (mode == M_IDENT) || (mode == M_STR) ||
                  (mode == M_STR_ESC) || (mode == M_EQ) || (mode == M_GT) ||
                  (mode == M_LT);
      mode_next = M_IDLE;
      tsl_next  = line;
      tsc_next  = col;
      sec_v     = 1'b1;
      sec       = mk_res(K_END, '0, '0, line, col, 1'b0);
    end else begin
      if (item.ch == 8'h0a) begin
        if (line != LINE_MAX) line_next = line + 24'd1;
        col_next = '0;
      end else if (col != COL_MAX) begin
        col_next = col + 16'd1;
      end

      case (mode)
        M_COMMENT: do_fresh = (item.ch == 8'h0a);
        M_STR, M_STR_ESC: begin
          mode_next = M_STR;
          if (mode == M_STR_ESC && item.ch == "n") begin
            tx_req = 1'b1;
            tx_ch  = 8'h0a;
          end else if (mode == M_STR_ESC && item.ch == "t") begin
            tx_req = 1'b1;
            tx_ch  = 8'h09;
          end else if (mode == M_STR_ESC && item.ch == "r") begin
            tx_req = 1'b1;
            tx_ch  = 8'h0d;
          end else if (item.ch == 8'h22) begin
            sec_v     = 1'b1;
            sec       = mk_res(K_STRING, '0, '0, tsl, tsc, ovf);
            mode_next = M_IDLE;
          end else if (item.ch == 8'h5c) begin
            mode_next = M_STR_ESC;
          end else begin
            tx_req = 1'b1;
          end
        end
        M_NUM: begin
          if (item.digit) begin
            if (acc_x10 > {4'd0, NUM_MAX}) begin
              acc_next = NUM_MAX;
              ovf_next = 1'b1;
            end else begin
              acc_next = acc_x10[62:0];
            end
          end else begin
            use_fl   = 1'b1;
            do_fresh = 1'b1;
          end
        end
        M_IDENT: begin
          if (item.id_char) tx_req = 1'b1;
          else begin
            use_fl   = 1'b1;
            do_fresh = 1'b1;
          end
        end
        M_EQ, M_GT, M_LT: begin
          if (item.ch == "=") begin
            sec_v     = 1'b1;
            sec       = mk_res((mode == M_EQ) ? K_EQEQ : ((mode == M_GT) ? K_GE : K_LE),
                               '0, '0, tsl, tsc, 1'b0);
            mode_next = M_IDLE;
          end else begin
            use_fl   = 1'b1;
            do_fresh = 1'b1;
          end
        end
        default: do_fresh = 1'b1;
      endcase

      if (tx_req) begin
        if (tlen < TLEN_W'(MAX_TEXT)) begin
          case (tlen[2:0])
            3'd0: win_next[7:0]   = tx_ch;
            3'd1: win_next[15:8]  = tx_ch;
            3'd2: win_next[23:16] = tx_ch;
            3'd3: win_next[31:24] = tx_ch;
            3'd4: win_next[39:32] = tx_ch;
            default: win_next = win;
          endcase
          if (tlen > TLEN_W'(4)) win_next = win;
          tlen_next = tlen + TLEN_W'(1);
          sec_v     = 1'b1;
          sec       = mk_res(K_TEXT, '0, tx_ch, tsl, tsc, 1'b0);
        end else begin
          ovf_next = 1'b1;
        end
      end

      if (do_fresh) begin
        tsl_next  = line;
        tsc_next  = col;
        mode_next = fr_mode;
        acc_next  = item.digit ? {59'd0, dig} : '0;
        ovf_next  = 1'b0;
        sec_v     = fr_v;
        sec       = fr;
        if (fr_mode == M_IDENT) begin
          win_next  = {32'd0, item.ch};
          tlen_next = TLEN_W'(1);
        end else begin
          win_next  = '0;
          tlen_next = '0;
        end
      end
    end

    rpush.r1      = sec;
    rpush.r1.last = 1'b1;
    if (use_fl) begin
      rpush.r0      = fl;
      rpush.r0.last = !sec_v;
      rpush.n       = sec_v ? 2'd2 : 2'd1;
    end else begin
      rpush.r0      = sec;
      rpush.r0.last = 1'b1;
      rpush.n       = sec_v ? 2'd1 : 2'd0;
    end
    if (!fire) rpush.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nl_end <= 1'b0;
      mode   <= M_IDLE;
      acc    <= '0;
      win    <= '0;
      tlen   <= '0;
      ovf    <= 1'b0;
      tsl    <= '0;
      tsc    <= '0;
      line   <= '0;
      col    <= '0;
    end else begin
      if (cfg_valid) nl_end <= cfg_data;
      if (fire) begin
        mode <= mode_next;
        acc  <= acc_next;
        win  <= win_next;
        tlen <= tlen_next;
        ovf  <= ovf_next;
        tsl  <= tsl_next;
        tsc  <= tsc_next;
        line <= line_next;
        col  <= col_next;
      end
    end
  end

endmodule

@@ rtl/core/stok_outq.sv @@
module stok_outq
  import stok_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  rpush_t  rpush,
  output logic    space_ok,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  result_t    q [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic       rd;

  assign space_ok = (count <= 3'd2);
  assign empty    = (count == 3'd0);
  assign rd       = pop && !empty;
  assign result   = q[rptr];

  always_ff @(posedge clk) begin
    if (rpush.n != 2'd0) q[wptr] <= rpush.r0;
    if (rpush.n == 2'd2) q[wptr + 2'd1] <= rpush.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + rpush.n;
      if (rd) rptr <= rptr + 2'd1;
      count <= count + {1'b0, rpush.n} - {2'd0, rd};
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue over depth");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (rpush.n != 2'd0) |-> (count <= 3'd2))
    else $error("results written without room");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (rd && rpush.n == 2'd0) |=> (count == $past(count) - 3'd1))
    else $error("queue count lost on pop");
`endif

endmodule

@@ rtl/core/source_tokenizer.sv @@
// Source tokenizer.
// Input side is a queue: present source with push while full is low; each item
// is one source byte, or end_of_input to flush the pending token and give END.
// Result side is a queue: while empty is low, result holds the oldest token or
// text item; pop takes it. Each input item gives zero, one or two results, and
// result.last marks the final one of an item.
// cfg_valid/cfg_ready writes newline_ends_input; ready is always high. Write it
// only while no items are in flight.
// Flow: an item is classified into a two-entry queue, then scanned one per
// cycle, while the result queue has room, into a four-entry result queue from
// which its results are read. One item per cycle is sustained while results
// are drained; items giving two results are limited by the single result pop
// per cycle.
// The scanner waits until the result queue has room for two results; when the
// receiver stalls, both queues fill and full rises. Nothing is dropped.
// Synchronous reset clears all scan state, counts, queues and the register.
module source_tokenizer
  import stok_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  source_t source,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data
);

  logic   fvalid, take, space_ok;
  cls_t   head;
  rpush_t rpush;

  assign cfg_ready = 1'b1;

  stok_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .source(source),
    .full  (full),
    .valid (fvalid),
    .head  (head),
    .take  (take)
  );

  stok_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .valid    (fvalid),
    .item     (head),
    .space_ok (space_ok),
    .take     (take),
    .rpush    (rpush)
  );

  stok_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .rpush   (rpush),
    .space_ok(space_ok),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
